// ===== hdl/bpr_pkg.sv =====
// Shared types and constants for the byte pattern replace unit.
// Used by bpr_cell and byte_pattern_replace_unit; no dependencies.
package bpr_pkg;

  // Configuration register indexes (byte address is 8 times the index).
  localparam logic [2:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [2:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [2:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [2:0] REG_CASE_SENSITIVE     = 3'd4;

  // Compare source of a window cell.
  localparam logic [1:0] SEL_OWN      = 2'd0;
  localparam logic [1:0] SEL_NEIGHBOR = 2'd1;
  localparam logic [1:0] SEL_INPUT    = 2'd2;

  typedef struct packed {
    logic       load;   // take the incoming text byte
    logic       shift;  // take the byte of the next cell up
    logic [1:0] sel;    // which byte is compared against the pattern
  } bpr_cell_ctrl_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hdl/bpr_cell.sv =====
// One window cell: holds a text byte, shifts toward the output end and
// compares a selected byte against its pattern byte. Depends on bpr_pkg.
module bpr_cell (
  input  logic                    clk,
  input  bpr_pkg::bpr_cell_ctrl_t ctrl,
  input  logic [7:0]              in_byte,
  input  logic [7:0]              neighbor_byte,
  input  logic [7:0]              pat_byte,
  input  logic                    fold,
  output logic [7:0]              cur_byte,
  output logic                    eq
);
  import bpr_pkg::*;

  logic [7:0] data;
  logic [7:0] cand;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= in_byte;
    end else if (ctrl.shift) begin
      data <= neighbor_byte;
    end
  end

  always_comb begin
    case (ctrl.sel)
      SEL_OWN:      cand = data;
      SEL_NEIGHBOR: cand = neighbor_byte;
      SEL_INPUT:    cand = in_byte;
      default:      cand = data;
    endcase
  end

  assign eq       = fold ? (upcase(cand) == upcase(pat_byte)) : (cand == pat_byte);
  assign cur_byte = data;

endmodule

// ===== hdl/byte_pattern_replace_unit.sv =====
// Byte pattern replace unit: a row of window cells, a small sequencer and an output beat register.
// An accepted input beat is held in a pending register; result beats are registered in the
// output beat register. Throughput is one byte per cycle unless the input beat is held: by a
// waiting output beat with m_tready low where a beat must be emitted, by further replacement
// bytes after a match, by the window draining after a last beat, or by surplus bytes popping.
// Reset (rst, synchronous) empties the window and the output and restores register defaults.
module byte_pattern_replace_unit #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic        clk,
  input  logic        rst,
  // text input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [1:0]  m_tuser,   // [0] out_valid, [1] replaced_any
  output logic        m_tlast,   // out_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import bpr_pkg::*;

  localparam int FW  = $clog2(PATTERN_MAX + 1);
  localparam int RW  = $clog2(REPLACE_MAX + 1);
  localparam int RIW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  localparam logic [1:0] PH_MAIN  = 2'd0;
  localparam logic [1:0] PH_REP   = 2'd1;
  localparam logic [1:0] PH_FLUSH = 2'd2;

  // Configuration registers
  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;
  logic        case_sensitive;

  logic [2:0] reg_idx;
  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= '0;
      case_sensitive     <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_PATTERN_BYTES:      pattern_bytes      <= pwdata;
        REG_PATTERN_LENGTH:     pattern_length     <= pwdata[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= pwdata;
        REG_REPLACEMENT_LENGTH: replacement_length <= pwdata[3:0];
        REG_CASE_SENSITIVE:     case_sensitive     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_BYTES:      prdata = pattern_bytes;
      REG_PATTERN_LENGTH:     prdata = {60'd0, pattern_length};
      REG_REPLACEMENT_BYTES:  prdata = replacement_bytes;
      REG_REPLACEMENT_LENGTH: prdata = {60'd0, replacement_length};
      REG_CASE_SENSITIVE:     prdata = {63'd0, case_sensitive};
      default:                prdata = '0;
    endcase
  end

  // Effective lengths after clamping
  logic [FW-1:0] plen;
  logic [RW-1:0] rlen;

  always_comb begin
    if (pattern_length == 4'd0) begin
      plen = FW'(1);
    end else if (pattern_length > 4'(PATTERN_MAX)) begin
      plen = FW'(PATTERN_MAX);
    end else begin
      plen = pattern_length[FW-1:0];
    end
    if (replacement_length > 4'(REPLACE_MAX)) begin
      rlen = RW'(REPLACE_MAX);
    end else begin
      rlen = replacement_length[RW-1:0];
    end
  end

  logic [7:0] rep_byte [REPLACE_MAX];
  for (genvar j = 0; j < REPLACE_MAX; j++) begin : g_rep
    assign rep_byte[j] = replacement_bytes[8*j +: 8];
  end

  // Control state
  logic          pend_valid;
  logic [7:0]    pend_byte;
  logic          pend_last;
  logic [1:0]    phase;
  logic [1:0]    phase_next;
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic          match_seen;
  logic          match_seen_next;
  logic [RIW-1:0] rcnt;
  logic [RIW-1:0] rcnt_next;

  // Output beat register
  logic       o_valid;
  logic [7:0] o_byte;
  logic       o_flag;
  logic       o_last;
  logic       o_rany;

  // Window cell row
  bpr_cell_ctrl_t   ctrl [PATTERN_MAX];
  logic [7:0]       win  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] in_pat;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [7:0] nb;
    if (i == PATTERN_MAX - 1) begin : g_end
      assign nb = 8'd0;
    end else begin : g_mid
      assign nb = win[i+1];
    end
    assign in_pat[i] = (FW'(i) < plen);
    bpr_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl[i]),
      .in_byte       (pend_byte),
      .neighbor_byte (nb),
      .pat_byte      (pattern_bytes[8*i +: 8]),
      .fold          (!case_sensitive),
      .cur_byte      (win[i]),
      .eq            (eq[i])
    );
  end

  logic match_all;
  assign match_all = &(eq | ~in_pat);

  logic       slot_free;
  logic       emit;
  logic       done;
  logic [7:0] e_byte;
  logic       e_flag;
  logic       e_last;
  logic       e_rany;
  logic       prepop;

  assign slot_free = !o_valid || m_tready;
  assign prepop    = (fill >= plen);

  always_comb begin
    emit            = 1'b0;
    done            = 1'b0;
    e_byte          = 8'd0;
    e_flag          = 1'b1;
    e_last          = 1'b0;
    e_rany          = 1'b0;
    phase_next      = phase;
    fill_next       = fill;
    match_seen_next = match_seen;
    rcnt_next       = rcnt;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      ctrl[i].load  = 1'b0;
      ctrl[i].shift = 1'b0;
      // Before a surplus pop, compare the window as it will stand after the pop and the push.
      if (prepop) begin
        ctrl[i].sel = (FW'(i + 1) < plen) ? SEL_NEIGHBOR : SEL_INPUT;
      end else begin
        ctrl[i].sel = (FW'(i) < fill) ? SEL_OWN : SEL_INPUT;
      end
    end

    if (pend_valid) begin
      case (phase)
        PH_MAIN: begin
          if (prepop) begin
            if (slot_free) begin
              emit   = 1'b1;
              e_byte = win[0];
              // The last surplus pop is final when the pushed byte completes a match that
              // emits nothing.
              if ((fill == plen) && pend_last && match_all && (rlen == '0)) begin
                e_last          = 1'b1;
                e_rany          = 1'b1;
                done            = 1'b1;
                fill_next       = '0;
                match_seen_next = 1'b0;
              end else begin
                fill_next = fill - FW'(1);
              end
              for (int i = 0; i < PATTERN_MAX; i++) begin
                ctrl[i].shift = 1'b1;
              end
            end
          end else if (((fill + FW'(1)) == plen) && match_all) begin
            if (rlen == '0) begin
              if (!pend_last) begin
                done            = 1'b1;
                fill_next       = '0;
                match_seen_next = 1'b1;
              end else if (slot_free) begin
                emit            = 1'b1;
                e_flag          = 1'b0;
                e_last          = 1'b1;
                e_rany          = 1'b1;
                done            = 1'b1;
                fill_next       = '0;
                match_seen_next = 1'b0;
              end
            end else if (slot_free) begin
              emit            = 1'b1;
              e_byte          = rep_byte[0];
              fill_next       = '0;
              match_seen_next = 1'b1;
              if (rlen == RW'(1)) begin
                done = 1'b1;
                if (pend_last) begin
                  e_last          = 1'b1;
                  e_rany          = 1'b1;
                  match_seen_next = 1'b0;
                end
              end else begin
                phase_next = PH_REP;
                rcnt_next  = RIW'(1);
              end
            end
          end else if ((fill + FW'(1)) == plen) begin
            if (slot_free) begin
              emit   = 1'b1;
              e_byte = (fill == '0) ? pend_byte : win[0];
              for (int i = 0; i < PATTERN_MAX; i++) begin
                ctrl[i].shift = (FW'(i + 1) < fill);
                ctrl[i].load  = (FW'(i + 1) == fill);
              end
              if (fill == '0) begin
                done = 1'b1;
                if (pend_last) begin
                  e_last          = 1'b1;
                  e_rany          = match_seen;
                  match_seen_next = 1'b0;
                end
              end else if (pend_last) begin
                phase_next = PH_FLUSH;
              end else begin
                done = 1'b1;
              end
            end
          end else begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
              ctrl[i].load = (FW'(i) == fill);
            end
            fill_next = fill + FW'(1);
            if (pend_last) begin
              phase_next = PH_FLUSH;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_REP: begin
          if (slot_free) begin
            emit      = 1'b1;
            e_byte    = rep_byte[rcnt];
            rcnt_next = rcnt + RIW'(1);
            if ((RW'(rcnt) + RW'(1)) == rlen) begin
              done       = 1'b1;
              phase_next = PH_MAIN;
              if (pend_last) begin
                e_last          = 1'b1;
                e_rany          = 1'b1;
                match_seen_next = 1'b0;
              end
            end
          end
        end
        PH_FLUSH: begin
          if (slot_free) begin
            emit      = 1'b1;
            e_byte    = win[0];
            fill_next = fill - FW'(1);
            for (int i = 0; i < PATTERN_MAX; i++) begin
              ctrl[i].shift = 1'b1;
            end
            if (fill == FW'(1)) begin
              done            = 1'b1;
              phase_next      = PH_MAIN;
              e_last          = 1'b1;
              e_rany          = match_seen;
              match_seen_next = 1'b0;
            end
          end
        end
        default: begin
          phase_next = PH_MAIN;
        end
      endcase
    end
  end

  assign s_tready = !pend_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      phase      <= PH_MAIN;
      fill       <= '0;
      match_seen <= 1'b0;
      rcnt       <= '0;
      o_valid    <= 1'b0;
    end else begin
      phase      <= phase_next;
      fill       <= fill_next;
      match_seen <= match_seen_next;
      rcnt       <= rcnt_next;
      if (s_tvalid && s_tready) begin
        pend_valid <= 1'b1;
      end else if (done) begin
        pend_valid <= 1'b0;
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pend_byte <= s_tdata;
      pend_last <= s_tlast;
    end
    if (emit) begin
      o_byte <= e_byte;
      o_flag <= e_flag;
      o_last <= e_last;
      o_rany <= e_rany;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_byte;
  assign m_tuser  = {o_rany, o_flag};
  assign m_tlast  = o_last;

  // The window never holds more bytes than it has cells.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(PATTERN_MAX))
    else $error("window fill beyond cell count");

  // Replacement and flush phases always work on a held input beat.
  a_phase_pend: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_MAIN) |-> pend_valid)
    else $error("sequencer busy without an input beat");

  // A flush always has at least one byte left to send.
  a_flush_fill: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FLUSH) |-> (fill != '0))
    else $error("flush with an empty window");

  // An empty closing beat only follows a deleting match, so it reports a replacement.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && !m_tuser[0]) |-> m_tuser[1])
    else $error("empty closing beat without replacement flag");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for byte_pattern_replace_unit: text beats in, result beats out,
// an APB port for the pattern, the replacement and the compare mode.
// Depends on bpr_pkg and the RTL of byte_pattern_replace_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bpr_pkg::*;

  localparam int unsigned RANDOM_BYTES  = 340;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned STALL_LIMIT   = 3000;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       replaced;
  } text_beat_t;

  // Tracks the window, the registers and the result beats still owed by the block.
  class replace_checker;
    logic [7:0]  window [8];
    int unsigned fill;
    bit          seen;
    logic [63:0] pattern;
    logic [63:0] replacement;
    logic [3:0]  pattern_len;
    logic [3:0]  replace_len;
    bit          exact;
    text_beat_t  beats_due [$];
    text_beat_t  staged [32];
    int unsigned staged_n;
    int unsigned errors;
    int unsigned bytes_in;
    int unsigned beats_out;
    int unsigned replacements;
    int unsigned texts;

    function new();
      foreach (window[i]) window[i] = '0;
      fill = 0;
      seen = 0;
      pattern = '0;
      replacement = '0;
      pattern_len = 4'd1;
      replace_len = 4'd0;
      exact = 1;
      staged_n = 0;
      errors = 0;
      bytes_in = 0;
      beats_out = 0;
      replacements = 0;
      texts = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_BYTES:      pattern = value;
        REG_PATTERN_LENGTH:     pattern_len = value[3:0];
        REG_REPLACEMENT_BYTES:  replacement = value;
        REG_REPLACEMENT_LENGTH: replace_len = value[3:0];
        REG_CASE_SENSITIVE:     exact = value[0];
        default: ;
      endcase
    endfunction

    // Out-of-range lengths are clamped the same way the block clamps them.
    function int unsigned active_len();
      if (pattern_len == 4'd0) return 1;
      if (pattern_len > 4'd8) return 8;
      return pattern_len;
    endfunction

    function int unsigned pending();
      return beats_due.size();
    endfunction

    function void stage(logic [7:0] data, logic valid);
      staged[staged_n] = '{data: data, valid: valid, last: 1'b0, replaced: 1'b0};
      staged_n++;
    endfunction

    function void pass_oldest();
      int i;
      stage(window[0], 1'b1);
      for (i = 0; i < 7; i++) window[i] = window[i + 1];
      window[7] = '0;
      fill--;
    endfunction

    function logic [7:0] fold(logic [7:0] c);
      if (!exact && c >= 8'h61 && c <= 8'h7a) return c - 8'h20;
      return c;
    endfunction

    function void note_byte(logic [7:0] data, logic last);
      int unsigned plen;
      int unsigned rlen;
      int i;
      bit hit;
      plen = active_len();
      rlen = (replace_len > 4'd8) ? 8 : replace_len;
      staged_n = 0;
      bytes_in++;
      // A pattern shortened since the last byte first drains the surplus.
      while (fill >= plen) pass_oldest();
      window[fill] = data;
      fill++;
      if (fill == plen) begin
        hit = 1;
        for (i = 0; i < plen; i++) begin
          if (fold(window[i]) != fold(pattern[8*i +: 8])) hit = 0;
        end
        if (hit) begin
          for (i = 0; i < rlen; i++) stage(replacement[8*i +: 8], 1'b1);
          foreach (window[j]) window[j] = '0;
          fill = 0;
          seen = 1;
          replacements++;
        end else begin
          pass_oldest();
        end
      end
      if (last) begin
        while (fill > 0) pass_oldest();
        if (staged_n == 0) stage(8'h00, 1'b0);
        staged[staged_n - 1].last = 1'b1;
        staged[staged_n - 1].replaced = seen;
        foreach (window[j]) window[j] = '0;
        fill = 0;
        seen = 0;
        texts++;
      end
      for (i = 0; i < staged_n; i++) beats_due.push_back(staged[i]);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [7:0] data, logic valid, logic last, logic replaced);
      text_beat_t want;
      beats_out++;
      if (beats_due.size() == 0) begin
        $error("result beat 0x%0h arrived with no beat expected", data);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      compare("out_byte", want.data, data);
      compare("out_valid", {7'd0, want.valid}, {7'd0, valid});
      compare("out_last", {7'd0, want.last}, {7'd0, last});
      compare("replaced_any", {7'd0, want.replaced}, {7'd0, replaced});
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  replace_checker sb;
  bit             no_idle;
  bit             hold_request;
  int unsigned    bytes_sent;
  int unsigned    reg_writes;
  int unsigned    quiet;

  byte_pattern_replace_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Register write: setup phase, then access phase until pready, then an idle bus before the task returns.
  task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    reg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(data, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Waits until every owed beat has come out, then lets the pipeline empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h61;
      2:       return 8'h41;
      3:       return 8'h62;
      4:       return 8'h42;
      5:       return 8'h00;
      6:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_config();
    logic [63:0] pat;
    logic [3:0]  plen;
    int i;
    for (i = 0; i < 8; i++) pat[8*i +: 8] = pick_byte();
    if ($urandom_range(0, 3) == 0) pat = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) begin
      plen = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
    end else begin
      plen = 4'($urandom_range(1, 8));
    end
    if ($urandom_range(0, 9) < 7) apb_write(REG_PATTERN_BYTES, pat);
    if ($urandom_range(0, 9) < 7) apb_write(REG_PATTERN_LENGTH, {60'd0, plen});
    if ($urandom_range(0, 9) < 7) apb_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
    if ($urandom_range(0, 9) < 7) apb_write(REG_REPLACEMENT_LENGTH, 64'($urandom_range(0, 15)));
    if ($urandom_range(0, 9) < 7) apb_write(REG_CASE_SENSITIVE, 64'($urandom_range(0, 1)));
  endtask

  // Texts are mostly built from copies of the pattern, with partial copies and noise mixed in.
  task automatic send_text(input int unsigned len, input bit close);
    logic [7:0] text_q [$];
    logic [7:0] c;
    int unsigned plen;
    int unsigned cut;
    int unsigned k;
    int unsigned pick;
    plen = sb.active_len();
    while (text_q.size() < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        cut = (pick < 10) ? $urandom_range(1, plen) : plen;
        for (k = 0; k < cut; k++) begin
          c = sb.pattern[8*k +: 8];
          if (!sb.exact && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7a &&
              $urandom_range(0, 1) == 1) begin
            c = c ^ 8'h20;
          end
          text_q.push_back(c);
        end
      end else begin
        text_q.push_back(pick_byte());
      end
    end
    for (k = 0; k < text_q.size(); k++) begin
      send_byte(text_q[k], close && (k == text_q.size() - 1));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_beat(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat moved for %0d cycles, %0d beats still owed",
             STALL_LIMIT, sb.pending());
    $display("byte_pattern_replace_unit: mismatch");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned n_texts;
    int unsigned t;
    int unsigned directed;
    logic [63:0] pat;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    bytes_sent = 0;
    reg_writes = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: a zero byte matches and is deleted, leaving an empty closing beat.
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);

    // Case-insensitive three-byte pattern, then a text shorter than the pattern.
    settle();
    apb_write(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
    apb_write(REG_PATTERN_LENGTH, 64'd3);
    apb_write(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_5958);
    apb_write(REG_REPLACEMENT_LENGTH, 64'd2);
    apb_write(REG_CASE_SENSITIVE, 64'd0);
    send_byte(8'h7a, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h61, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);

    // Pattern length zero acts as one; replacement length above the maximum is clamped.
    settle();
    apb_write(REG_PATTERN_BYTES, 64'hffff_ffff_ffff_ffff);
    apb_write(REG_PATTERN_LENGTH, 64'd0);
    apb_write(REG_REPLACEMENT_BYTES, 64'h8040_2010_0804_0201);
    apb_write(REG_REPLACEMENT_LENGTH, 64'd15);
    apb_write(REG_CASE_SENSITIVE, 64'd1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b1);

    // Full eight-byte pattern through an oversized length setting.
    settle();
    pat = 64'h0123_4567_89ab_cdef;
    apb_write(REG_PATTERN_BYTES, pat);
    apb_write(REG_PATTERN_LENGTH, 64'd15);
    apb_write(REG_REPLACEMENT_BYTES, 64'hfedc_ba98_7654_3210);
    apb_write(REG_REPLACEMENT_LENGTH, 64'd8);
    for (t = 0; t < 8; t++) send_byte(pat[8*t +: 8], 1'b0);
    send_byte(8'h55, 1'b1);

    // Shorten the pattern while three bytes of an open text sit in the window.
    settle();
    apb_write(REG_PATTERN_BYTES, 64'h0000_0000_4443_4241);
    apb_write(REG_PATTERN_LENGTH, 64'd4);
    apb_write(REG_REPLACEMENT_LENGTH, 64'd1);
    send_byte(8'h78, 1'b0);
    send_byte(8'h79, 1'b0);
    send_byte(8'h7a, 1'b0);
    settle();
    apb_write(REG_PATTERN_LENGTH, 64'd2);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);

    directed = bytes_sent;
    phase = 0;
    while (bytes_sent < directed + RANDOM_BYTES) begin
      settle();
      random_config();
      no_idle = (phase == 2);
      if (phase == 4) hold_request = 1'b1;
      n_texts = $urandom_range(2, 5);
      for (t = 0; t < n_texts; t++) begin
        send_text(($urandom_range(0, 4) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 10),
                  (t != n_texts - 1) || ($urandom_range(0, 4) != 0));
      end
      phase++;
    end
    no_idle = 1'b0;
    settle();

    $display("Sent %0d text bytes over %0d register writes and %0d random phases;",
             bytes_sent, reg_writes, phase);
    $display("checked %0d result beats across %0d closed texts with %0d replacements.",
             sb.beats_out, sb.texts, sb.replacements);
    if (sb.errors == 0) begin
      $display("byte_pattern_replace_unit: match");
    end else begin
      $display("byte_pattern_replace_unit: mismatch");
    end
    $finish;
  end

endmodule
